// ===== sv/v3a_pkg.sv =====
// Shared types, opcodes and saturation helper for the Q16.16 vector ALU.
// No dependencies; imported by every module of the block.
`default_nettype none

package v3a_pkg;

   localparam int WORD_W        = 32;
   localparam int OP_W          = 4;
   localparam int FRAC_BITS_DEF = 16;
   localparam int PROD_W        = 2 * WORD_W;
   localparam int SUM_W         = PROD_W + 2;
   localparam int SQRT_STAGES   = WORD_W;
   localparam int LANES         = 3;

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 4'd0,
      OP_SUB   = 4'd1,
      OP_MUL   = 4'd2,
      OP_NEG   = 4'd3,
      OP_CROSS = 4'd4,
      OP_DOT   = 4'd5,
      OP_LENSQ = 4'd6,
      OP_LEN   = 4'd7,
      OP_NORM  = 4'd8,
      OP_SCALE = 4'd9,
      OP_DIV   = 4'd10
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]          opcode;
      logic signed [WORD_W-1:0] ax;
      logic signed [WORD_W-1:0] ay;
      logic signed [WORD_W-1:0] az;
      logic signed [WORD_W-1:0] bx;
      logic signed [WORD_W-1:0] by;
      logic signed [WORD_W-1:0] bz;
      logic signed [WORD_W-1:0] scalar_operand;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] rx;
      logic signed [WORD_W-1:0] ry;
      logic signed [WORD_W-1:0] rz;
      logic signed [WORD_W-1:0] scalar_result;
      logic                     defined;
      logic                     saturated;
   } rsp_type;

   typedef struct packed {
      logic [WORD_W-1:0] val;
      logic              sat;
   } sat_type;

   // item context carried alongside the root and divide pipelines
   typedef struct packed {
      logic [OP_W-1:0]              opcode;
      logic [LANES-1:0][WORD_W-1:0] a;
      logic [WORD_W-1:0]            s;
      logic [LANES-1:0][WORD_W-1:0] r;
      logic                         rsat;
      logic [WORD_W-1:0]            dot;
      logic                         dsat;
      logic [WORD_W-1:0]            len;
   } side_type;

   function automatic sat_type sat_word(input logic signed [SUM_W-1:0] v);
      sat_type res;
      if (v[SUM_W-1:WORD_W-1] == '0 || v[SUM_W-1:WORD_W-1] == '1) begin
         res.val = v[WORD_W-1:0];
         res.sat = 1'b0;
      end else begin
         res.val = v[SUM_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
         res.sat = 1'b1;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== sv/v3a_lane.sv =====
// One component lane: operand select, two multipliers, then add/sub/shift and clamp.
// Depends on v3a_pkg.
`default_nettype none

module v3a_lane
   import v3a_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic [OP_W-1:0]          op,
   input  wire logic signed [WORD_W-1:0] a_i,
   input  wire logic signed [WORD_W-1:0] b_i,
   input  wire logic signed [WORD_W-1:0] a_j,
   input  wire logic signed [WORD_W-1:0] b_k,
   input  wire logic signed [WORD_W-1:0] a_k,
   input  wire logic signed [WORD_W-1:0] b_j,
   input  wire logic signed [WORD_W-1:0] s,
   output logic signed [PROD_W-1:0]      prod_ff,
   output sat_type                       res_ff
);

   logic [OP_W-1:0]          op_ff;
   logic signed [WORD_W-1:0] a_ff, b_ff;
   logic signed [PROD_W-1:0] p1_ff;
   logic signed [WORD_W-1:0] m0a, m0b, m1a, m1b;
   logic signed [PROD_W-1:0] prod_in, p1_in;
   logic signed [SUM_W-1:0]  t;
   sat_type                  res_in;

   always_comb begin
      m0a = '0;
      m0b = '0;
      m1a = '0;
      m1b = '0;
      case (op)
         OP_MUL, OP_DOT: begin
            m0a = a_i;
            m0b = b_i;
         end
         OP_CROSS: begin
            m0a = a_j;
            m0b = b_k;
            m1a = a_k;
            m1b = b_j;
         end
         OP_LENSQ, OP_LEN, OP_NORM: begin
            m0a = a_i;
            m0b = a_i;
         end
         OP_SCALE: begin
            m0a = a_i;
            m0b = s;
         end
         default: begin
         end
      endcase
      prod_in = m0a * m0b;
      p1_in   = m1a * m1b;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op_ff   <= op;
         a_ff    <= a_i;
         b_ff    <= b_i;
         prod_ff <= prod_in;
         p1_ff   <= p1_in;
         res_ff  <= res_in;
      end
   end

   always_comb begin
      t = '0;
      case (op_ff)
         OP_ADD:   t = SUM_W'(a_ff) + SUM_W'(b_ff);
         OP_SUB:   t = SUM_W'(a_ff) - SUM_W'(b_ff);
         OP_NEG:   t = -SUM_W'(a_ff);
         OP_MUL, OP_SCALE: begin
            t = SUM_W'(prod_ff);
            t = t >>> FRAC_BITS;
         end
         OP_CROSS: begin
            t = SUM_W'(prod_ff) - SUM_W'(p1_ff);
            t = t >>> FRAC_BITS;
         end
         default: t = '0;
      endcase
      res_in = sat_word(t);
   end

endmodule

`default_nettype wire

// ===== sv/v3a_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, 64-bit radicand.
// Depends on v3a_pkg.
`default_nettype none

module v3a_sqrt
   import v3a_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                en,
   input  wire logic [PROD_W-1:0]   rad,
   output logic [WORD_W-1:0]        root
);

   localparam int REM_W = WORD_W + 3;

   logic [REM_W-1:0]  rem_ff [SQRT_STAGES];
   logic [WORD_W-1:0] q_ff   [SQRT_STAGES];
   logic [PROD_W-1:0] n_ff   [SQRT_STAGES];
   logic [REM_W-1:0]  rem_in [SQRT_STAGES];
   logic [WORD_W-1:0] q_in   [SQRT_STAGES];
   logic [PROD_W-1:0] n_in   [SQRT_STAGES];

   always_comb begin
      logic [REM_W-1:0]  rp, rt, tr;
      logic [WORD_W-1:0] qp;
      logic [PROD_W-1:0] np;
      for (int k = 0; k < SQRT_STAGES; k++) begin
         if (k == 0) begin
            rp = '0;
            qp = '0;
            np = rad;
         end else begin
            rp = rem_ff[k-1];
            qp = q_ff[k-1];
            np = n_ff[k-1];
         end
         rt = {rp[REM_W-3:0], np[PROD_W-1:PROD_W-2]};
         tr = REM_W'({qp, 2'b01});
         if (rt >= tr) begin
            rem_in[k] = rt - tr;
            q_in[k]   = {qp[WORD_W-2:0], 1'b1};
         end else begin
            rem_in[k] = rt;
            q_in[k]   = {qp[WORD_W-2:0], 1'b0};
         end
         n_in[k] = {np[PROD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SQRT_STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            n_ff[k]   <= n_in[k];
         end
      end
   end

   assign root = q_ff[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== sv/v3a_div.sv =====
// Pipelined restoring divider for one lane, one quotient bit per stage.
// Depends on v3a_pkg.
`default_nettype none

module v3a_div
   import v3a_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [WORD_W+FRAC_BITS-1:0]   num,
   input  wire logic [WORD_W-1:0]             den,
   output logic [WORD_W+FRAC_BITS-1:0]        quot
);

   localparam int NUM_W = WORD_W + FRAC_BITS;
   localparam int REM_W = WORD_W + 1;

   logic [REM_W-1:0]  rem_ff [NUM_W];
   logic [NUM_W-1:0]  n_ff   [NUM_W];
   logic [NUM_W-1:0]  q_ff   [NUM_W];
   logic [WORD_W-1:0] d_ff   [NUM_W];
   logic [REM_W-1:0]  rem_in [NUM_W];
   logic [NUM_W-1:0]  n_in   [NUM_W];
   logic [NUM_W-1:0]  q_in   [NUM_W];
   logic [WORD_W-1:0] d_in   [NUM_W];

   always_comb begin
      logic [REM_W-1:0]  rp, rt;
      logic [NUM_W-1:0]  np, qp;
      logic [WORD_W-1:0] dp;
      for (int k = 0; k < NUM_W; k++) begin
         if (k == 0) begin
            rp = '0;
            np = num;
            qp = '0;
            dp = den;
         end else begin
            rp = rem_ff[k-1];
            np = n_ff[k-1];
            qp = q_ff[k-1];
            dp = d_ff[k-1];
         end
         rt = {rp[WORD_W-1:0], np[NUM_W-1]};
         if (rt >= {1'b0, dp}) begin
            rem_in[k] = rt - {1'b0, dp};
            q_in[k]   = {qp[NUM_W-2:0], 1'b1};
         end else begin
            rem_in[k] = rt;
            q_in[k]   = {qp[NUM_W-2:0], 1'b0};
         end
         n_in[k] = {np[NUM_W-2:0], 1'b0};
         d_in[k] = dp;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NUM_W; k++) begin
            rem_ff[k] <= rem_in[k];
            n_ff[k]   <= n_in[k];
            q_ff[k]   <= q_in[k];
            d_ff[k]   <= d_in[k];
         end
      end
   end

   assign quot = q_ff[NUM_W-1];

endmodule

`default_nettype wire

// ===== sv/vec3_fixed_point_alu_core.sv =====
// Q16.16 three-component vector ALU: three lanes, shared root pipeline, lane dividers.
// Each item passes the lane registers, the dot-product register, the 32-stage root pipeline,
// the one-bit-per-stage dividers and the response register before rsp_valid.
// Throughput: one item per cycle; a stalled result freezes the whole pipeline.
// Reset clears only the stage valid bits. Depends on v3a_pkg, v3a_lane, v3a_sqrt, v3a_div.
`default_nettype none

module vec3_fixed_point_alu_core
   import v3a_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int NUM_W      = WORD_W + FRAC_BITS;
   localparam int DIV_STAGES = NUM_W;

   logic en;
   logic v1_ff, v2_ff, rsp_valid_ff;
   logic sq_v_ff [SQRT_STAGES];
   logic dv_v_ff [DIV_STAGES];

   req_type s1_ff, s2_ff;
   logic signed [SUM_W-1:0]  dot_ff, dot_in;
   logic signed [PROD_W-1:0] prod [LANES];
   sat_type                  lres [LANES];

   side_type side0, side1;
   side_type sq_side_ff [SQRT_STAGES];
   side_type dv_side_ff [DIV_STAGES];
   logic [WORD_W-1:0] root;
   logic [NUM_W-1:0]  num  [LANES];
   logic [NUM_W-1:0]  quot [LANES];
   logic [WORD_W-1:0] den;

   rsp_type rsp_data_ff, rsp_data_in;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < SQRT_STAGES; k++) sq_v_ff[k] <= 1'b0;
         for (int k = 0; k < DIV_STAGES; k++) dv_v_ff[k] <= 1'b0;
      end else if (en) begin
         v1_ff      <= req_valid;
         v2_ff      <= v1_ff;
         sq_v_ff[0] <= v2_ff;
         for (int k = 1; k < SQRT_STAGES; k++) sq_v_ff[k] <= sq_v_ff[k-1];
         dv_v_ff[0] <= sq_v_ff[SQRT_STAGES-1];
         for (int k = 1; k < DIV_STAGES; k++) dv_v_ff[k] <= dv_v_ff[k-1];
         rsp_valid_ff <= dv_v_ff[DIV_STAGES-1];
      end
   end

   v3a_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
      .clock(clock), .en(en), .op(req_data.opcode),
      .a_i(req_data.ax), .b_i(req_data.bx),
      .a_j(req_data.ay), .b_k(req_data.bz), .a_k(req_data.az), .b_j(req_data.by),
      .s(req_data.scalar_operand), .prod_ff(prod[0]), .res_ff(lres[0])
   );

   v3a_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
      .clock(clock), .en(en), .op(req_data.opcode),
      .a_i(req_data.ay), .b_i(req_data.by),
      .a_j(req_data.az), .b_k(req_data.bx), .a_k(req_data.ax), .b_j(req_data.bz),
      .s(req_data.scalar_operand), .prod_ff(prod[1]), .res_ff(lres[1])
   );

   v3a_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
      .clock(clock), .en(en), .op(req_data.opcode),
      .a_i(req_data.az), .b_i(req_data.bz),
      .a_j(req_data.ax), .b_k(req_data.by), .a_k(req_data.ay), .b_j(req_data.bx),
      .s(req_data.scalar_operand), .prod_ff(prod[2]), .res_ff(lres[2])
   );

   assign dot_in = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]);

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff  <= req_data;
         s2_ff  <= s1_ff;
         dot_ff <= dot_in;
      end
   end

   always_comb begin
      logic signed [SUM_W-1:0] dq;
      sat_type                 ds;
      dq = dot_ff >>> FRAC_BITS;
      ds = sat_word(dq);
      side0.opcode = s2_ff.opcode;
      side0.a      = {s2_ff.az, s2_ff.ay, s2_ff.ax};
      side0.s      = s2_ff.scalar_operand;
      side0.r      = {lres[2].val, lres[1].val, lres[0].val};
      side0.rsat   = lres[0].sat | lres[1].sat | lres[2].sat;
      side0.dot    = ds.val;
      side0.dsat   = ds.sat;
      side0.len    = '0;
   end

   v3a_sqrt u_sqrt (
      .clock(clock), .en(en), .rad(dot_ff[PROD_W-1:0]), .root(root)
   );

   always_comb begin
      logic [WORD_W-1:0] mag;
      side1     = sq_side_ff[SQRT_STAGES-1];
      side1.len = root;
      if (side1.opcode == OP_DIV) begin
         den = side1.s[WORD_W-1] ? WORD_W'(-side1.s) : side1.s;
      end else begin
         den = root;
      end
      for (int i = 0; i < LANES; i++) begin
         mag    = side1.a[i][WORD_W-1] ? WORD_W'(-side1.a[i]) : side1.a[i];
         num[i] = {mag, {FRAC_BITS{1'b0}}};
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_div
      v3a_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock(clock), .en(en), .num(num[g]), .den(den), .quot(quot[g])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_side_ff[0] <= side0;
         for (int k = 1; k < SQRT_STAGES; k++) sq_side_ff[k] <= sq_side_ff[k-1];
         dv_side_ff[0] <= side1;
         for (int k = 1; k < DIV_STAGES; k++) dv_side_ff[k] <= dv_side_ff[k-1];
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_comb begin
      side_type                sd;
      logic signed [SUM_W-1:0] t;
      sat_type                 dr [LANES];
      sat_type                 ls;
      logic                    neg;
      logic                    dsat;
      sd = dv_side_ff[DIV_STAGES-1];
      dsat = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         neg   = sd.a[i][WORD_W-1] ^ (sd.opcode == OP_DIV && sd.s[WORD_W-1]);
         t     = SUM_W'(quot[i]);
         dr[i] = sat_word(neg ? -t : t);
         dsat  = dsat | dr[i].sat;
      end
      ls = sat_word(SUM_W'(sd.len));
      rsp_data_in = '0;
      rsp_data_in.defined = 1'b1;
      case (sd.opcode)
         OP_ADD, OP_SUB, OP_MUL, OP_NEG, OP_CROSS, OP_SCALE: begin
            rsp_data_in.rx        = sd.r[0];
            rsp_data_in.ry        = sd.r[1];
            rsp_data_in.rz        = sd.r[2];
            rsp_data_in.saturated = sd.rsat;
         end
         OP_DOT, OP_LENSQ: begin
            rsp_data_in.scalar_result = sd.dot;
            rsp_data_in.saturated     = sd.dsat;
         end
         OP_LEN: begin
            rsp_data_in.scalar_result = ls.val;
            rsp_data_in.saturated     = ls.sat;
         end
         OP_NORM: begin
            if (sd.len != '0) begin
               rsp_data_in.rx        = dr[0].val;
               rsp_data_in.ry        = dr[1].val;
               rsp_data_in.rz        = dr[2].val;
               rsp_data_in.saturated = dsat;
            end
         end
         OP_DIV: begin
            if (sd.s == '0) begin
               rsp_data_in.rx      = sd.a[0];
               rsp_data_in.ry      = sd.a[1];
               rsp_data_in.rz      = sd.a[2];
               rsp_data_in.defined = 1'b0;
            end else begin
               rsp_data_in.rx        = dr[0].val;
               rsp_data_in.ry        = dr[1].val;
               rsp_data_in.rz        = dr[2].val;
               rsp_data_in.saturated = dsat;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire
